>>> src/blc_pkg.sv
package blc_pkg;

  localparam int ADC_W  = 12;
  localparam int NUM_CODES = 5;
  localparam int SUM_W  = 15;
  localparam int UV_W   = 23;
  localparam int OFF_W  = 18;
  localparam int SEG_W  = 3;
  localparam int PCT_W  = 15;
  localparam int LVL_W  = 7;
  localparam int RCP_W  = 23;

  // microvolt scaling: uv = sum * 80000 / 273 (avg of five codes, 3.0 V ref, 2:1 divider)
  // 80000 = 273 * 293 + 11, the fractional part goes through a reciprocal multiply
  localparam logic [8:0]  VOLT_INT   = 9'd293;
  localparam logic [3:0]  VOLT_REM   = 4'd11;
  localparam logic [17:0] RCP_273    = 18'd245821;
  localparam int          RCP_273_SH = 26;
  localparam int          VOLT_FRAC_W = 10;
  localparam int          REM_W      = 18;

  localparam logic [UV_W-1:0] UV_EMPTY = 23'd3300000;
  localparam logic [UV_W-1:0] UV_FULL  = 23'd4200000;

  // interpolation quotient uses ceil(2^27 * dp / dv) per segment
  localparam int INTERP_SH = 27;
  localparam int INTERP_Q_W = 13;

  // divide by 5 for the smoothing filter
  localparam int          NUM_W   = 17;
  localparam logic [16:0] RCP_5   = 17'd104858;
  localparam int          RCP_5_SH = 19;

  localparam logic [PCT_W-1:0] PCT_MAX = 15'd25600;
  localparam logic [LVL_W-1:0] LVL_MAX = 7'd100;

  typedef struct packed {
    logic load;
    logic scale;
    logic volt;
    logic seg;
    logic interp;
    logic filt;
    logic wb;
  } blc_cmd_t;

  // breakpoints including the empty and full ends, segment i runs from breakpoint i to i+1
  function automatic logic [UV_W-1:0] curve_uv(input logic [SEG_W-1:0] idx);
    logic [UV_W-1:0] v;
    unique case (idx)
      3'd0:    v = 23'd3300000;
      3'd1:    v = 23'd3500000;
      3'd2:    v = 23'd3700000;
      3'd3:    v = 23'd3850000;
      3'd4:    v = 23'd4000000;
      3'd5:    v = 23'd4100000;
      3'd6:    v = 23'd4200000;
      default: v = 23'd4200000;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] seg_base(input logic [SEG_W-1:0] idx);
    logic [PCT_W-1:0] b;
    unique case (idx)
      3'd0:    b = 15'd0;
      3'd1:    b = 15'd2560;
      3'd2:    b = 15'd7680;
      3'd3:    b = 15'd14080;
      3'd4:    b = 15'd20480;
      3'd5:    b = 15'd23040;
      default: b = 15'd0;
    endcase
    return b;
  endfunction

  // slope reciprocals: 8/625, 16/625, 16/375 scaled by 2^27
  function automatic logic [RCP_W-1:0] seg_recip(input logic [SEG_W-1:0] idx);
    logic [RCP_W-1:0] m;
    unique case (idx)
      3'd0:    m = 23'd1717987;
      3'd1:    m = 23'd3435974;
      3'd2:    m = 23'd5726624;
      3'd3:    m = 23'd5726624;
      3'd4:    m = 23'd3435974;
      3'd5:    m = 23'd3435974;
      default: m = 23'd0;
    endcase
    return m;
  endfunction

endpackage

>>> src/battery_level_conditioner_core.sv
// an accepted item passes through the scale, volt, seg, interp, filt and write-back steps before its result is valid
// in_ready stays low until the six-step controller sequence
// after the accepting cycle has finished; a result waiting at the output stalls only the write-back step
// reset: synchronous active-low rst_n clears the controller, the smoothed average,
// its seeded flag and the published level; the first item after reset seeds the average
module battery_level_conditioner_core
  import blc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ADC_W-1:0] in_adc_code_a,
  input  logic [ADC_W-1:0] in_adc_code_b,
  input  logic [ADC_W-1:0] in_adc_code_c,
  input  logic [ADC_W-1:0] in_adc_code_d,
  input  logic [ADC_W-1:0] in_adc_code_e,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LVL_W-1:0] out_charge_level,
  output logic             out_level_changed,
  output logic [PCT_W-1:0] out_filtered_percent
);

  blc_cmd_t cmd;

  blc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  blc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .adc_code_a       (in_adc_code_a),
    .adc_code_b       (in_adc_code_b),
    .adc_code_c       (in_adc_code_c),
    .adc_code_d       (in_adc_code_d),
    .adc_code_e       (in_adc_code_e),
    .charge_level     (out_charge_level),
    .level_changed    (out_level_changed),
    .filtered_percent (out_filtered_percent)
  );

endmodule

>>> src/blc_ctrl.sv
module blc_ctrl
  import blc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output blc_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCALE  = 7'b0000010,
    ST_VOLT   = 7'b0000100,
    ST_SEG    = 7'b0001000,
    ST_INTERP = 7'b0010000,
    ST_FILT   = 7'b0100000,
    ST_WB     = 7'b1000000
  } blc_state_t;

  blc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_VOLT;
      end
      ST_VOLT: begin
        cmd.volt  = 1'b1;
        state_nxt = ST_SEG;
      end
      ST_SEG: begin
        cmd.seg   = 1'b1;
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_nxt  = ST_FILT;
      end
      ST_FILT: begin
        cmd.filt  = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        // hold the result until the output register is free
        if (slot_free) begin
          cmd.wb    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.wb) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/blc_dp.sv
module blc_dp
  import blc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  blc_cmd_t         cmd,
  input  logic [ADC_W-1:0] adc_code_a,
  input  logic [ADC_W-1:0] adc_code_b,
  input  logic [ADC_W-1:0] adc_code_c,
  input  logic [ADC_W-1:0] adc_code_d,
  input  logic [ADC_W-1:0] adc_code_e,
  output logic [LVL_W-1:0] charge_level,
  output logic             level_changed,
  output logic [PCT_W-1:0] filtered_percent
);

  localparam int VPROD_W = REM_W + REM_W;
  localparam int IPROD_W = OFF_W + RCP_W;
  localparam int FPROD_W = NUM_W + NUM_W;

  logic [SUM_W-1:0]   sum_r;
  logic [UV_W-1:0]    int_r;
  logic [REM_W-1:0]   rem_r;
  logic [UV_W-1:0]    uv_r;
  logic [OFF_W-1:0]   off_r;
  logic [SEG_W-1:0]   seg_r;
  logic               lo_r, hi_r;
  logic [PCT_W-1:0]   pct_r;
  logic [PCT_W-1:0]   filt_r;
  logic [PCT_W-1:0]   smoothed_r;
  logic               seeded_r;
  logic [LVL_W-1:0]   published_r;
  logic [LVL_W-1:0]   level_out_r;
  logic               changed_out_r;
  logic [PCT_W-1:0]   filt_out_r;

  logic [SUM_W-1:0]   code_sum;
  logic [UV_W-1:0]    scale_int;
  logic [REM_W-1:0]   scale_rem;
  logic [VPROD_W-1:0] volt_prod;
  logic [UV_W-1:0]    uv_val;
  logic [SEG_W-1:0]   seg_idx;
  logic [UV_W-1:0]    off_full;
  logic [IPROD_W-1:0] interp_prod;
  logic [PCT_W-1:0]   pct_val;
  logic [NUM_W-1:0]   ema_num;
  logic [FPROD_W-1:0] ema_prod;
  logic [PCT_W-1:0]   ema_q;
  logic [PCT_W-1:0]   filt_val;
  logic [PCT_W:0]     lvl_sum;
  logic [7:0]         lvl_raw;
  logic [LVL_W-1:0]   lvl_new;
  logic               change;

  assign code_sum = SUM_W'(adc_code_a) + SUM_W'(adc_code_b) + SUM_W'(adc_code_c)
                  + SUM_W'(adc_code_d) + SUM_W'(adc_code_e);

  assign scale_int = UV_W'(sum_r) * UV_W'(VOLT_INT);
  assign scale_rem = REM_W'(sum_r) * REM_W'(VOLT_REM);

  // floor(rem / 273) by reciprocal multiply, exact for every rem that five 12-bit codes can produce
  assign volt_prod = VPROD_W'(rem_r) * VPROD_W'(RCP_273);
  assign uv_val    = int_r + UV_W'(volt_prod[RCP_273_SH +: VOLT_FRAC_W]);

  // first segment whose upper breakpoint is not below the voltage
  always_comb begin
    seg_idx = '0;
    for (int j = 1; j < 6; j++) begin
      if (uv_r > curve_uv(SEG_W'(j))) begin
        seg_idx = seg_idx + SEG_W'(1);
      end
    end
  end
  assign off_full = uv_r - curve_uv(seg_idx);

  assign interp_prod = IPROD_W'(off_r) * IPROD_W'(seg_recip(seg_r));

  always_comb begin
    priority if (lo_r) begin
      pct_val = '0;
    end else if (hi_r) begin
      pct_val = PCT_MAX;
    end else begin
      pct_val = seg_base(seg_r) + PCT_W'(interp_prod[INTERP_SH +: INTERP_Q_W]);
    end
  end

  // (p + 4 f + 2) / 5, reciprocal exact for the numerator range
  assign ema_num  = NUM_W'(pct_r) + {smoothed_r, 2'b00} + NUM_W'(2);
  assign ema_prod = FPROD_W'(ema_num) * FPROD_W'(RCP_5);
  assign ema_q    = ema_prod[RCP_5_SH +: PCT_W];

  always_comb begin
    filt_val = seeded_r ? ema_q : pct_r;
    if (filt_val > PCT_MAX) begin
      filt_val = PCT_MAX;
    end
  end

  assign lvl_sum = (PCT_W+1)'(filt_r) + (PCT_W+1)'(128);
  assign lvl_raw = lvl_sum[PCT_W:8];
  assign lvl_new = (lvl_raw > 8'(LVL_MAX)) ? LVL_MAX : lvl_raw[LVL_W-1:0];

  assign change = (published_r == '0)
               || ({1'b0, lvl_new} >= {1'b0, published_r} + 8'd2)
               || ({1'b0, published_r} >= {1'b0, lvl_new} + 8'd2);

  always_ff @(posedge clk) begin
    if (cmd.load)   sum_r <= code_sum;
    if (cmd.scale) begin
      int_r <= scale_int;
      rem_r <= scale_rem;
    end
    if (cmd.volt)   uv_r <= uv_val;
    if (cmd.seg) begin
      off_r <= off_full[OFF_W-1:0];
      seg_r <= seg_idx;
      lo_r  <= (uv_r <= UV_EMPTY);
      hi_r  <= (uv_r >= UV_FULL);
    end
    if (cmd.interp) pct_r <= pct_val;
    if (cmd.filt)   filt_r <= filt_val;
    if (cmd.wb) begin
      level_out_r   <= change ? lvl_new : published_r;
      changed_out_r <= change;
      filt_out_r    <= filt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r  <= '0;
      seeded_r    <= 1'b0;
      published_r <= '0;
    end else if (cmd.wb) begin
      smoothed_r <= filt_r;
      seeded_r   <= 1'b1;
      if (change) begin
        published_r <= lvl_new;
      end
    end
  end

  assign charge_level     = level_out_r;
  assign level_changed    = changed_out_r;
  assign filtered_percent = filt_out_r;

endmodule

>>> src/blc_checker.sv
module blc_checker
  import blc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [ADC_W-1:0] in_adc_code_a,
  input logic [ADC_W-1:0] in_adc_code_b,
  input logic [ADC_W-1:0] in_adc_code_c,
  input logic [ADC_W-1:0] in_adc_code_d,
  input logic [ADC_W-1:0] in_adc_code_e,
  input logic             out_valid,
  input logic             out_ready,
  input logic [LVL_W-1:0] out_charge_level,
  input logic             out_level_changed,
  input logic [PCT_W-1:0] out_filtered_percent
);

  // a stalled item keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_charge_level)
      && $stable(out_level_changed) && $stable(out_filtered_percent))
    else $error("result item changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_charge_level <= LVL_MAX && out_filtered_percent <= PCT_MAX)
    else $error("result item out of range");

  // a held level is never zero, zero always republishes
  a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_level_changed |-> out_charge_level != '0)
    else $error("zero level held without update");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

endmodule

bind battery_level_conditioner_core blc_checker u_blc_checker (.*);
